// ===== sv/wav_header_validator_assert.svh =====
// Assertion macros for the WAV header validator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef WAV_HEADER_VALIDATOR_ASSERT_SVH
`define WAV_HEADER_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WVH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WVH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wvh_pkg.sv =====
// Shared types, codes and lookup functions for the WAV header validator.
// No dependencies; used by wvh_parse, wvh_out and wav_header_validator.
`timescale 1ns / 1ps

package wvh_pkg;

  // Status codes, in the order the checks run
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_RIFF     = 4'd1;
  localparam logic [3:0] ST_WAVE     = 4'd2;
  localparam logic [3:0] ST_FMT      = 4'd3;
  localparam logic [3:0] ST_FORMAT   = 4'd4;
  localparam logic [3:0] ST_CHANNELS = 4'd5;
  localparam logic [3:0] ST_RATE     = 4'd6;
  localparam logic [3:0] ST_BITS     = 4'd7;
  localparam logic [3:0] ST_FRAME    = 4'd8;
  localparam logic [3:0] ST_DATA     = 4'd9;
  localparam logic [3:0] ST_LENGTH   = 4'd10;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Chunk tags, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_LPCM = 16'h0001;
  localparam logic [5:0]  HDR_LAST = 6'd43;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  status;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [15:0] frame_bytes;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_payload;
  } res_t;

  function automatic logic rate_ok(input logic [31:0] r);
    logic ok;
    case (r)
      32'd8000, 32'd11025, 32'd16000, 32'd22050,
      32'd24000, 32'd32000, 32'd44100, 32'd48000: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    return tag[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== sv/wvh_parse.sv =====
// Parser state and per-byte header checks / payload passing.
// Uses wvh_pkg; state advances on each accepted request.
`timescale 1ns / 1ps

module wvh_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              start_file,
  output logic              res_valid,
  output wvh_pkg::res_t     res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_IDLE    = 2'd2;

  logic [1:0]  phase_r, phase_nxt, phase_eff;
  logic [5:0]  pos_r, pos_nxt, pos_eff;
  logic [3:0]  err_r, err_nxt, err_eff;
  logic [31:0] left_r, left_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] fs_r, fs_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] dlen_r, dlen_nxt;

  logic [3:0]  code;
  logic [15:0] fmt_m, ch_m, bits_m, fs_expect;
  logic [31:0] rate_m, dlen_m, trunc;
  logic [32:0] len_sum;

  // Merged values for the cycle that completes each field
  assign fmt_m   = {data_byte, fmt_r[7:0]};
  assign ch_m    = {data_byte, ch_r[7:0]};
  assign bits_m  = {data_byte, bits_r[7:0]};
  assign rate_m  = {data_byte, rate_r[23:0]};
  assign dlen_m  = {data_byte, dlen_r[23:0]};
  assign len_sum = {1'b0, dlen_m} + 33'd36;
  // Only used with one or two channels of 8 or 16 bits; else an earlier error stands
  assign fs_expect = (ch_m == 16'd2) ? ((bits_m == 16'd16) ? 16'd4 : 16'd2)
                                     : ((bits_m == 16'd16) ? 16'd2 : 16'd1);
  // Frame size is 1, 2 or 4 when no error, so truncation is a mask
  assign trunc = dlen_m & ~({16'd0, fs_r} - 32'd1);

  always_comb begin
    phase_eff = start_file ? PH_HEADER : phase_r;
    pos_eff   = start_file ? 6'd0 : pos_r;
    err_eff   = start_file ? wvh_pkg::ST_OK : err_r;

    phase_nxt = phase_eff;
    pos_nxt   = pos_eff;
    err_nxt   = err_eff;
    left_nxt  = left_r;
    riff_nxt  = riff_r;
    fmt_nxt   = fmt_r;
    ch_nxt    = ch_r;
    rate_nxt  = rate_r;
    fs_nxt    = fs_r;
    bits_nxt  = bits_r;
    dlen_nxt  = dlen_r;
    code      = wvh_pkg::ST_OK;
    res_valid = 1'b0;
    res       = '0;

    case (phase_eff)
      PH_HEADER: begin
        if (pos_eff <= 6'd3) begin
          if (data_byte != wvh_pkg::tag_byte(wvh_pkg::TAG_RIFF, pos_eff[1:0]))
            code = wvh_pkg::ST_RIFF;
        end else if (pos_eff <= 6'd7) begin
          riff_nxt[{pos_eff[1:0], 3'b000} +: 8] = data_byte;
        end else if (pos_eff <= 6'd11) begin
          if (data_byte != wvh_pkg::tag_byte(wvh_pkg::TAG_WAVE, pos_eff[1:0]))
            code = wvh_pkg::ST_WAVE;
        end else if (pos_eff <= 6'd15) begin
          if (data_byte != wvh_pkg::tag_byte(wvh_pkg::TAG_FMT, pos_eff[1:0]))
            code = wvh_pkg::ST_FMT;
        end else if (pos_eff == 6'd20 || pos_eff == 6'd21) begin
          fmt_nxt[{pos_eff[0], 3'b000} +: 8] = data_byte;
          if (pos_eff[0] && fmt_m != wvh_pkg::FMT_LPCM) code = wvh_pkg::ST_FORMAT;
        end else if (pos_eff == 6'd22 || pos_eff == 6'd23) begin
          ch_nxt[{pos_eff[0], 3'b000} +: 8] = data_byte;
          if (pos_eff[0] && ch_m != 16'd1 && ch_m != 16'd2) code = wvh_pkg::ST_CHANNELS;
        end else if (pos_eff >= 6'd24 && pos_eff <= 6'd27) begin
          rate_nxt[{pos_eff[1:0], 3'b000} +: 8] = data_byte;
          if (pos_eff == 6'd27 && !wvh_pkg::rate_ok(rate_m)) code = wvh_pkg::ST_RATE;
        end else if (pos_eff == 6'd32 || pos_eff == 6'd33) begin
          fs_nxt[{pos_eff[0], 3'b000} +: 8] = data_byte;
        end else if (pos_eff == 6'd34 || pos_eff == 6'd35) begin
          bits_nxt[{pos_eff[0], 3'b000} +: 8] = data_byte;
          if (pos_eff[0]) begin
            if (bits_m != 16'd8 && bits_m != 16'd16) code = wvh_pkg::ST_BITS;
            else if (fs_r != fs_expect) code = wvh_pkg::ST_FRAME;
          end
        end else if (pos_eff >= 6'd36 && pos_eff <= 6'd39) begin
          if (data_byte != wvh_pkg::tag_byte(wvh_pkg::TAG_DATA, pos_eff[1:0]))
            code = wvh_pkg::ST_DATA;
        end else if (pos_eff >= 6'd40) begin
          dlen_nxt[{pos_eff[1:0], 3'b000} +: 8] = data_byte;
          if (pos_eff == wvh_pkg::HDR_LAST && len_sum != {1'b0, riff_r})
            code = wvh_pkg::ST_LENGTH;
        end

        if (err_eff == wvh_pkg::ST_OK) err_nxt = code;

        if (pos_eff == wvh_pkg::HDR_LAST) begin
          pos_nxt               = 6'd0;
          res_valid             = 1'b1;
          res.result_kind       = wvh_pkg::KIND_HEADER;
          res.status            = err_nxt;
          res.num_channels      = ch_r;
          res.sample_rate       = rate_r;
          res.sample_bits       = bits_r;
          res.frame_bytes       = fs_r;
          if (err_nxt == wvh_pkg::ST_OK && fs_r != 16'd0) begin
            left_nxt           = trunc;
            res.payload_length = trunc;
            phase_nxt          = (trunc != 32'd0) ? PH_PAYLOAD : PH_IDLE;
          end else begin
            left_nxt  = 32'd0;
            phase_nxt = PH_IDLE;
          end
        end else begin
          pos_nxt = pos_eff + 6'd1;
        end
      end
      PH_PAYLOAD: begin
        if (left_r != 32'd0) begin
          res_valid        = 1'b1;
          res.result_kind  = wvh_pkg::KIND_PAYLOAD;
          res.payload_byte = data_byte;
          res.last_payload = (left_r == 32'd1);
          left_nxt         = left_r - 32'd1;
          if (left_r == 32'd1) phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= 6'd0;
      err_r   <= wvh_pkg::ST_OK;
      left_r  <= 32'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      left_r  <= left_nxt;
    end
  end

  // Header words are fully rewritten each pass before use
  always_ff @(posedge clk) begin
    if (acc) begin
      riff_r <= riff_nxt;
      fmt_r  <= fmt_nxt;
      ch_r   <= ch_nxt;
      rate_r <= rate_nxt;
      fs_r   <= fs_nxt;
      bits_r <= bits_nxt;
      dlen_r <= dlen_nxt;
    end
  end

endmodule

// ===== sv/wvh_out.sv =====
// Result register for the validator's output channel.
// Uses wvh_pkg::res_t; loads on an accepted request that yields a result.
`timescale 1ns / 1ps

module wvh_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          res_valid,
  input  wvh_pkg::res_t res,
  input  logic          out_stall,
  output logic          out_valid,
  output wvh_pkg::res_t out_res
);

  logic          valid_r, valid_nxt;
  wvh_pkg::res_t res_r;

  // acc only fires when this register is empty or draining
  always_comb begin
    valid_nxt = valid_r;
    if (acc) valid_nxt = res_valid;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== sv/wav_header_validator.sv =====
// Top level of the WAV header validator: parser plus result register.
// Depends on wvh_pkg, wvh_parse, wvh_out and wav_header_validator_assert.svh.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | data_byte, start_file
//   out_    | output    | out_valid/out_stall | header verdict or payload byte
//
// One byte per cycle while in_stall is low; a result appears in the cycle after its byte is taken.
// All checks for a byte happen in one pass from parser state to result register.
// Synchronous active-low reset returns the parser to the header phase.
// in_stall rises only while a held result is stalled at the output.
// start_file on any byte restarts parsing at header byte 0.
`timescale 1ns / 1ps
`include "wav_header_validator_assert.svh"

module wav_header_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [3:0]  out_status,
  output logic [15:0] out_num_channels,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_sample_bits,
  output logic [15:0] out_frame_bytes,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload
);

  logic          acc;
  logic          res_valid;
  wvh_pkg::res_t res;
  wvh_pkg::res_t out_res;

  assign in_stall = out_valid && out_stall;
  assign acc      = in_valid && !in_stall;

  wvh_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_data_byte),
    .start_file (in_start_file),
    .res_valid  (res_valid),
    .res        (res)
  );

  wvh_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_result_kind    = out_res.result_kind;
  assign out_status         = out_res.status;
  assign out_num_channels   = out_res.num_channels;
  assign out_sample_rate    = out_res.sample_rate;
  assign out_sample_bits    = out_res.sample_bits;
  assign out_frame_bytes    = out_res.frame_bytes;
  assign out_payload_length = out_res.payload_length;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_last_payload   = out_res.last_payload;

  `WVH_ASSERT_NOW(a_no_take_when_full, out_valid && out_stall, !acc, "request taken while result held")
  `WVH_ASSERT_NOW(a_fail_no_length, out_valid && out_result_kind == wvh_pkg::KIND_HEADER && out_status != wvh_pkg::ST_OK, out_payload_length == 32'd0, "length given with failed header")
  `WVH_ASSERT_NOW(a_payload_clean, out_valid && out_result_kind == wvh_pkg::KIND_PAYLOAD, out_status == wvh_pkg::ST_OK && out_payload_length == 32'd0, "payload result carries header fields")
  `WVH_ASSERT_NEXT(a_last_ends, acc && res_valid && res.last_payload, out_valid && out_last_payload, "last payload byte lost")

endmodule

// ===== bench/wvh_checker.sv =====
// Checker for the WAV header validator: watches both channels, parses the byte
// stream itself and compares every result against its own prediction.
// Depends on wvh_pkg for status codes, result kinds and chunk tags.
`timescale 1ns / 1ps

module wvh_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_file,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [3:0]  out_status,
  input  logic [15:0] out_num_channels,
  input  logic [31:0] out_sample_rate,
  input  logic [15:0] out_sample_bits,
  input  logic [15:0] out_frame_bytes,
  input  logic [31:0] out_payload_length,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_last_payload,
  output int          mismatch_cnt,
  output int          results_owed
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } wav_phase_t;

  wav_phase_t  phase;
  logic [5:0]  hdr_pos;
  logic [3:0]  hdr_err;
  logic [31:0] riff_len;
  logic [15:0] fmt_code;
  logic [15:0] chan_cnt;
  logic [31:0] rate_hz;
  logic [15:0] align_bytes;
  logic [15:0] bits_per;
  logic [31:0] data_len;
  logic [31:0] payload_left;

  wvh_pkg::res_t wav_results_q[$];
  wvh_pkg::res_t want;

  initial begin
    mismatch_cnt = 0;
    results_owed = 0;
  end

  function automatic logic std_rate(input logic [31:0] r);
    return (r == 32'd8000) || (r == 32'd11025) || (r == 32'd16000) ||
           (r == 32'd22050) || (r == 32'd24000) || (r == 32'd32000) ||
           (r == 32'd44100) || (r == 32'd48000);
  endfunction

  task automatic clear_parser();
    phase        = PH_HEADER;
    hdr_pos      = '0;
    hdr_err      = wvh_pkg::ST_OK;
    riff_len     = '0;
    fmt_code     = '0;
    chan_cnt     = '0;
    rate_hz      = '0;
    align_bytes  = '0;
    bits_per     = '0;
    data_len     = '0;
    payload_left = '0;
  endtask

  // only the first failing check is kept
  task automatic note_error(input logic [3:0] code);
    if (hdr_err == wvh_pkg::ST_OK) hdr_err = code;
  endtask

  task automatic step_parser(input logic [7:0] b, input logic sf);
    wvh_pkg::res_t r;
    logic [5:0]    p;
    logic [31:0]   prod;
    if (sf) clear_parser();
    r = '0;
    if (phase == PH_HEADER) begin
      p = hdr_pos;
      if (p <= 6'd3) begin
        if (b != wvh_pkg::TAG_RIFF[{p[1:0], 3'b000} +: 8]) note_error(wvh_pkg::ST_RIFF);
      end else if (p <= 6'd7) begin
        riff_len[{p[1:0], 3'b000} +: 8] = b;
      end else if (p <= 6'd11) begin
        if (b != wvh_pkg::TAG_WAVE[{p[1:0], 3'b000} +: 8]) note_error(wvh_pkg::ST_WAVE);
      end else if (p <= 6'd15) begin
        if (b != wvh_pkg::TAG_FMT[{p[1:0], 3'b000} +: 8]) note_error(wvh_pkg::ST_FMT);
      end else if (p == 6'd20 || p == 6'd21) begin
        fmt_code[{p[0], 3'b000} +: 8] = b;
        if (p == 6'd21 && fmt_code != wvh_pkg::FMT_LPCM) note_error(wvh_pkg::ST_FORMAT);
      end else if (p == 6'd22 || p == 6'd23) begin
        chan_cnt[{p[0], 3'b000} +: 8] = b;
        if (p == 6'd23 && chan_cnt != 16'd1 && chan_cnt != 16'd2)
          note_error(wvh_pkg::ST_CHANNELS);
      end else if (p >= 6'd24 && p <= 6'd27) begin
        rate_hz[{p[1:0], 3'b000} +: 8] = b;
        if (p == 6'd27 && !std_rate(rate_hz)) note_error(wvh_pkg::ST_RATE);
      end else if (p == 6'd32 || p == 6'd33) begin
        align_bytes[{p[0], 3'b000} +: 8] = b;
      end else if (p == 6'd34 || p == 6'd35) begin
        bits_per[{p[0], 3'b000} +: 8] = b;
        if (p == 6'd35) begin
          if (bits_per != 16'd8 && bits_per != 16'd16) note_error(wvh_pkg::ST_BITS);
          prod = 32'(chan_cnt) * 32'(bits_per);
          if (align_bytes != prod[18:3]) note_error(wvh_pkg::ST_FRAME);
        end
      end else if (p >= 6'd36 && p <= 6'd39) begin
        if (b != wvh_pkg::TAG_DATA[{p[1:0], 3'b000} +: 8]) note_error(wvh_pkg::ST_DATA);
      end else if (p >= 6'd40) begin
        data_len[{p[1:0], 3'b000} +: 8] = b;
        // 33-bit sum so a huge data length cannot wrap onto the RIFF length
        if (p == wvh_pkg::HDR_LAST && ({1'b0, data_len} + 33'd36) != {1'b0, riff_len})
          note_error(wvh_pkg::ST_LENGTH);
      end

      if (p != wvh_pkg::HDR_LAST) begin
        hdr_pos = p + 6'd1;
      end else begin
        hdr_pos           = '0;
        r.result_kind     = wvh_pkg::KIND_HEADER;
        r.status          = hdr_err;
        r.num_channels    = chan_cnt;
        r.sample_rate     = rate_hz;
        r.sample_bits     = bits_per;
        r.frame_bytes     = align_bytes;
        if (hdr_err == wvh_pkg::ST_OK && align_bytes != 16'd0) begin
          payload_left     = data_len - (data_len % align_bytes);
          r.payload_length = payload_left;
          phase            = (payload_left != 0) ? PH_PAYLOAD : PH_DONE;
        end else begin
          payload_left = '0;
          phase        = PH_DONE;
        end
        wav_results_q.push_back(r);
      end
    end else if (phase == PH_PAYLOAD && payload_left != 0) begin
      r.result_kind  = wvh_pkg::KIND_PAYLOAD;
      r.payload_byte = b;
      r.last_payload = (payload_left == 32'd1);
      payload_left   = payload_left - 32'd1;
      if (payload_left == 0) phase = PH_DONE;
      wav_results_q.push_back(r);
    end else begin
      phase = PH_DONE;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // results first: a request taken at this edge cannot have produced one yet
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      wav_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (wav_results_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0b status %0d",
                   $time, out_result_kind, out_status);
          mismatch_cnt++;
        end else begin
          want = wav_results_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_result_kind));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("num_channels", 32'(want.num_channels), 32'(out_num_channels));
          check_field("sample_rate", want.sample_rate, out_sample_rate);
          check_field("sample_bits", 32'(want.sample_bits), 32'(out_sample_bits));
          check_field("frame_bytes", 32'(want.frame_bytes), 32'(out_frame_bytes));
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_payload_byte));
          check_field("last_payload", 32'(want.last_payload), 32'(out_last_payload));
        end
      end
      if (in_valid && !in_stall) step_parser(in_data_byte, in_start_file);
    end
    results_owed <= wav_results_q.size();
  end

endmodule

// ===== bench/tb_wav_header_validator.sv =====
// Testbench top for the WAV header validator: builds WAV byte streams, drives
// them with random gaps and output stalls; depends on wvh_pkg and wvh_checker.
`timescale 1ns / 1ps

module tb_wav_header_validator;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 100;
  localparam int LONG_HOLD    = 40;

  typedef struct {
    logic [31:0] riff_tag;
    logic [31:0] riff_len;
    logic [31:0] wave_tag;
    logic [31:0] fmt_tag;
    logic [31:0] fmt_len;
    logic [15:0] format;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] byte_rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] data_tag;
    logic [31:0] dlen;
  } wav_hdr_t;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte  = 8'h00;
  logic        in_start_file = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        out_result_kind;
  logic [3:0]  out_status;
  logic [15:0] out_num_channels;
  logic [31:0] out_sample_rate;
  logic [15:0] out_sample_bits;
  logic [15:0] out_frame_bytes;
  logic [31:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_last_payload;

  int mismatch_cnt;
  int results_owed;
  int bytes_sent = 0;
  int cycle_cnt  = 0;
  bit no_gaps    = 1'b0;
  bit hold_long  = 1'b0;

  wav_header_validator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_file     (in_start_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_status        (out_status),
    .out_num_channels  (out_num_channels),
    .out_sample_rate   (out_sample_rate),
    .out_sample_bits   (out_sample_bits),
    .out_frame_bytes   (out_frame_bytes),
    .out_payload_length(out_payload_length),
    .out_payload_byte  (out_payload_byte),
    .out_last_payload  (out_last_payload)
  );

  wvh_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_file     (in_start_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_status        (out_status),
    .out_num_channels  (out_num_channels),
    .out_sample_rate   (out_sample_rate),
    .out_sample_bits   (out_sample_bits),
    .out_frame_bytes   (out_frame_bytes),
    .out_payload_length(out_payload_length),
    .out_payload_byte  (out_payload_byte),
    .out_last_payload  (out_last_payload),
    .mismatch_cnt      (mismatch_cnt),
    .results_owed      (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_wav_header_validator failed");
    $finish;
  end

  function automatic logic [31:0] pick_rate(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'd8000;
      1: r = 32'd11025;
      2: r = 32'd16000;
      3: r = 32'd22050;
      4: r = 32'd24000;
      5: r = 32'd32000;
      6: r = 32'd44100;
      default: r = 32'd48000;
    endcase
    return r;
  endfunction

  // consistent LPCM header for the given shape
  function automatic wav_hdr_t pcm_hdr(input logic [15:0] ch, input logic [15:0] bits,
                                       input logic [31:0] rate, input logic [31:0] dlen);
    wav_hdr_t h;
    h.riff_tag  = wvh_pkg::TAG_RIFF;
    h.riff_len  = dlen + 32'd36;
    h.wave_tag  = wvh_pkg::TAG_WAVE;
    h.fmt_tag   = wvh_pkg::TAG_FMT;
    h.fmt_len   = 32'd16;
    h.format    = wvh_pkg::FMT_LPCM;
    h.chans     = ch;
    h.rate      = rate;
    h.align     = 16'((32'(ch) * 32'(bits)) >> 3);
    h.byte_rate = rate * 32'(h.align);
    h.bits      = bits;
    h.data_tag  = wvh_pkg::TAG_DATA;
    h.dlen      = dlen;
    return h;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sf);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 8));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_start_file <= sf;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // hdr_cnt < 44 cuts the header short; flip_pos >= 0 corrupts one header byte
  task automatic send_file(input wav_hdr_t h, input int hdr_cnt, input int body,
                           input logic restart, input int flip_pos);
    logic [351:0] flat;
    int i;
    flat = {h.dlen, h.data_tag, h.bits, h.align, h.byte_rate, h.rate, h.chans,
            h.format, h.fmt_len, h.fmt_tag, h.wave_tag, h.riff_len, h.riff_tag};
    if (flip_pos >= 0) flat[8*flip_pos +: 8] ^= 8'($urandom_range(1, 255));
    for (i = 0; i < hdr_cnt; i++) send_byte(flat[8*i +: 8], restart && (i == 0));
    for (i = 0; i < body; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // sender goes idle until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic random_file();
    wav_hdr_t    h;
    int          pick;
    int          body;
    int          cut;
    int          flip;
    logic [31:0] dlen;
    pick    = int'($urandom_range(0, 99));
    no_gaps = ($urandom_range(0, 5) == 0);
    dlen    = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 40));
    h = pcm_hdr(16'($urandom_range(1, 2)), $urandom_range(0, 1) ? 16'd16 : 16'd8,
                pick_rate(int'($urandom_range(0, 7))), dlen);
    if ($urandom_range(0, 1)) begin
      h.fmt_len   = $urandom();
      h.byte_rate = $urandom();
    end
    cut  = 44;
    flip = -1;
    body = (dlen > 32'd40) ? 40 : int'(dlen);
    body = body + int'($urandom_range(0, 4));
    if (pick < 20) begin
      flip = int'($urandom_range(0, 43));
    end else if (pick < 30) begin
      case ($urandom_range(0, 5))
        0: h.format   = 16'($urandom());
        1: h.chans    = 16'($urandom());
        2: h.bits     = 16'($urandom());
        3: h.rate     = h.rate ^ (32'h1 << $urandom_range(0, 31));
        4: h.align    = 16'($urandom());
        default: h.riff_len = $urandom();
      endcase
    end else if (pick < 36) begin
      cut  = int'($urandom_range(1, 43));
      body = 0;
    end else if (pick < 40) begin
      h.riff_tag = $urandom();
      h.wave_tag = $urandom();
      h.chans    = 16'($urandom());
      h.rate     = $urandom();
      h.dlen     = $urandom();
    end
    send_file(h, cut, body, ($urandom_range(0, 19) != 0), flip);
  endtask

  // output side: random stall per result, one long hold when asked
  initial begin : receiver
    int wait_n;
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        wait_n    = LONG_HOLD;
      end else begin
        wait_n = no_gaps ? 0 : int'($urandom_range(0, 8));
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    wav_hdr_t h;
    int       random_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first file right out of reset, no start flag
    send_file(pcm_hdr(16'd1, 16'd8, 32'd8000, 32'd5), 44, 8, 1'b0, -1);
    // length not a whole number of frames, rounded down to whole stereo frames
    send_file(pcm_hdr(16'd2, 16'd16, 32'd48000, 32'd10), 44, 12, 1'b1, -1);
    // empty payload, and data shorter than one frame
    send_file(pcm_hdr(16'd1, 16'd16, 32'd11025, 32'd0), 44, 2, 1'b1, -1);
    send_file(pcm_hdr(16'd2, 16'd16, 32'd16000, 32'd3), 44, 2, 1'b1, -1);

    for (int code = int'(wvh_pkg::ST_RIFF); code <= int'(wvh_pkg::ST_LENGTH); code++) begin
      h = pcm_hdr(16'd1, 16'd8, 32'd22050, 32'd4);
      case (4'(code))
        wvh_pkg::ST_RIFF:     h.riff_tag[7:0] = 8'h00;
        wvh_pkg::ST_WAVE:     h.wave_tag[31:24] = 8'hFF;
        wvh_pkg::ST_FMT:      h.fmt_tag = '0;
        wvh_pkg::ST_FORMAT:   h.format = 16'hFFFF;
        wvh_pkg::ST_CHANNELS: h.chans = 16'd0;
        // matches only in the low half
        wvh_pkg::ST_RATE:     h.rate = 32'd44100 + 32'h0001_0000;
        wvh_pkg::ST_BITS:     begin h.bits = 16'd24; h.align = 16'd3; end
        wvh_pkg::ST_FRAME:    h.align = 16'd2;
        wvh_pkg::ST_DATA:     h.data_tag = 32'hFFFF_FFFF;
        // riff length wraps
        wvh_pkg::ST_LENGTH:   h = pcm_hdr(16'd2, 16'd16, 32'd32000, 32'hFFFF_FFF0);
        default:              ;
      endcase
      send_file(h, 44, 3, 1'b1, -1);
    end

    // largest legal length; output held off so the block backs up, then restart
    hold_long = 1'b1;
    send_file(pcm_hdr(16'd2, 16'd16, 32'd24000, 32'hFFFF_FFDB), 44, 20, 1'b1, -1);
    // header cut short by a new file
    send_file(pcm_hdr(16'd1, 16'd8, 32'd44100, 32'd6), 20, 0, 1'b1, -1);
    send_file(pcm_hdr(16'd1, 16'd8, 32'd32000, 32'd7), 44, 9, 1'b1, -1);

    // sender waits until every result is back
    drain();
    hold_long    = 1'b1;
    random_start = bytes_sent;
    while (bytes_sent < random_start + RANDOM_BYTES) random_file();

    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) $display("tb_wav_header_validator passed");
    else $display("tb_wav_header_validator failed");
    $finish;
  end

endmodule
